/* src/pixel_quadratic_cross_terms_assert.svh */
// Assertion macros used by the checker file.
`ifndef PIXEL_QUADRATIC_CROSS_TERMS_ASSERT_SVH
`define PIXEL_QUADRATIC_CROSS_TERMS_ASSERT_SVH

// Same-cycle implication, ignored while reset is held.
`define PQCT_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pqct assertion failed");

// Next-cycle implication, ignored while reset is held.
`define PQCT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pqct assertion failed");

`endif

/* src/pqct_pkg.sv */
package pqct_pkg;

    localparam int MAX_PIXELS   = 16;
    localparam int WEIGHT_DEPTH = MAX_PIXELS * (MAX_PIXELS + 1) / 2;
    localparam int PIX_IDX_W    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int POS_W        = $clog2(MAX_PIXELS + 1);
    localparam int WIDX_W       = $clog2(WEIGHT_DEPTH);

    localparam int CFG_W    = 5;
    localparam int PIX_W    = 16;
    localparam int WGT_W    = 24;
    localparam int WIN_W    = 8;
    localparam int SUM_W    = 48;
    localparam int PP_W     = 2 * PIX_W;
    localparam int PROD_W   = WGT_W + PP_W + 1;
    localparam int TERM_SHIFT = 24;
    localparam int TERM_W   = PROD_W - TERM_SHIFT;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic valid;   // a term operand pair enters the multiplier
        logic clear;   // zero the accumulator
    } mac_ctrl_t;

    // Clamp the configured count into 1..MAX_PIXELS.
    function automatic logic [POS_W-1:0] eff_count(input logic [CFG_W-1:0] c);
        logic [31:0] cw;
        cw = 32'(c);
        if (cw == 32'd0) begin
            return POS_W'(1);
        end else if (cw > 32'(MAX_PIXELS)) begin
            return POS_W'(MAX_PIXELS);
        end
        return POS_W'(cw);
    endfunction

endpackage

/* src/pqct_mac.sv */
module pqct_mac (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  pqct_pkg::mac_ctrl_t                ctrl,
    input  logic [pqct_pkg::PIX_W-1:0]         pj,
    input  logic [pqct_pkg::PIX_W-1:0]         pk,
    input  logic signed [pqct_pkg::WGT_W-1:0]  w,
    output logic                               busy,
    output logic signed [pqct_pkg::SUM_W-1:0]  sum
);
    import pqct_pkg::*;

    logic                     va_reg;
    logic                     vb_reg;
    logic [PP_W-1:0]          pp_reg;
    logic signed [WGT_W-1:0]  wa_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  sum_reg;

    logic signed [TERM_W-1:0] term;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W-1:0]  sum_sat;

    // floor shift: keep the upper bits of the product
    assign term     = prod_reg[PROD_W-1:TERM_SHIFT];
    assign sum_wide = {sum_reg[SUM_W-1], sum_reg} + {{(SUM_W+1-TERM_W){term[TERM_W-1]}}, term};

    always_comb begin
        case (sum_wide[SUM_W:SUM_W-1])
            2'b01:   sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
            2'b10:   sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
            default: sum_sat = sum_wide[SUM_W-1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        pp_reg   <= PP_W'(pj) * PP_W'(pk);
        wa_reg   <= w;
        prod_reg <= PROD_W'(wa_reg) * $signed({1'b0, pp_reg});
        if (!aresetn) begin
            va_reg  <= 1'b0;
            vb_reg  <= 1'b0;
            sum_reg <= '0;
        end else begin
            va_reg <= ctrl.valid;
            vb_reg <= va_reg;
            if (ctrl.clear) begin
                sum_reg <= '0;
            end else if (vb_reg) begin
                sum_reg <= sum_sat;
            end
        end
    end

    assign busy = va_reg | vb_reg;
    assign sum  = sum_reg;

endmodule

/* src/pixel_quadratic_cross_terms.sv */
// Pixel quadratic cross terms: frame sum of w[l]*p_j*p_k over j<=k.
// Weight load beat: ready again the next cycle.
// Pixel beat k (0-based): the block is busy from accept until back in idle; it issues k+1
// terms (one each through the shared multiplier pair), then drains the read and MAC stages.
// Last pixel of a frame adds an emit state, which waits while a held result is stalled.
// aresetn is synchronous, active low: clears FSM, sum, position, count to 16.
module pixel_quadratic_cross_terms (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration: pixel_count
    input  logic                         cfg_wr_en,
    input  logic [pqct_pkg::CFG_W-1:0]   cfg_wr_data,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [47:0]                  s_tdata,  // weight_index[7:0], weight_value[31:8],
                                                   // pixel_value[47:32]
    input  logic                         s_tuser,  // command
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [47:0]                  m_tdata   // frame_sum[47:0]
);
    import pqct_pkg::*;

    // payload unpack
    logic [WIN_W-1:0]        in_widx;
    logic signed [WGT_W-1:0] in_wval;
    logic [PIX_W-1:0]        in_pix;
    assign in_widx = s_tdata[7:0];
    assign in_wval = s_tdata[31:8];
    assign in_pix  = s_tdata[47:32];

    state_t state_reg, state_next;

    logic [CFG_W-1:0]        count_reg;
    logic [POS_W-1:0]        pos_reg;       // pixel position within frame
    logic [POS_W-1:0]        n_eff;

    // term sequencer
    logic [PIX_IDX_W-1:0]    j_reg;
    logic [PIX_IDX_W-1:0]    k_reg;
    logic [WIDX_W-1:0]       l_reg;         // weight address for current j
    logic [POS_W-1:0]        step_reg;      // l(j+1) - l(j) = n-1-j
    logic [PIX_W-1:0]        pk_reg;
    logic                    last_reg;      // this pixel closes the frame

    // storage
    logic signed [WGT_W-1:0] weight_mem [WEIGHT_DEPTH];
    logic [PIX_W-1:0]        pix_reg [MAX_PIXELS];

    // registered reads feeding the MAC
    logic signed [WGT_W-1:0] w_rd_reg;
    logic [PIX_W-1:0]        pj_rd_reg;
    logic                    rd_valid_reg;

    logic [SUM_W-1:0]        out_data_reg;
    logic                    out_valid_reg;

    logic                    in_fire;
    logic                    load_fire;
    logic                    pix_fire;
    logic                    issue;
    logic                    drained;
    logic                    emit_fire;

    mac_ctrl_t               mac_ctrl;
    logic                    mac_busy;
    logic signed [SUM_W-1:0] mac_sum;

    assign n_eff = eff_count(count_reg);

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tuser == CMD_PIXEL) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (j_reg == k_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_valid_reg && !mac_busy) begin
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- outputs / strobes ----------------
    always_comb begin
        s_tready       = (state_reg == ST_IDLE);
        in_fire        = s_tvalid && s_tready;
        load_fire      = in_fire && (s_tuser == CMD_LOAD);
        pix_fire       = in_fire && (s_tuser == CMD_PIXEL);
        issue          = (state_reg == ST_ISSUE);
        drained        = (state_reg == ST_DRAIN) && !rd_valid_reg && !mac_busy;
        emit_fire      = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);
        mac_ctrl.valid = rd_valid_reg;
        mac_ctrl.clear = emit_fire || cfg_wr_en;
    end

    // ---------------- memories ----------------
    always_ff @(posedge aclk) begin
        if (load_fire && 32'(in_widx) < 32'(WEIGHT_DEPTH)) begin
            weight_mem[in_widx[WIDX_W-1:0]] <= in_wval;
        end
        w_rd_reg <= weight_mem[l_reg];
    end

    always_ff @(posedge aclk) begin
        if (pix_fire) begin
            pix_reg[pos_reg[PIX_IDX_W-1:0]] <= in_pix;
        end
        pj_rd_reg <= pix_reg[j_reg];
    end

    // ---------------- sequencer datapath ----------------
    always_ff @(posedge aclk) begin
        if (pix_fire) begin
            // j = 0 starts at l = k; increments shrink by one per step
            pk_reg   <= in_pix;
            k_reg    <= pos_reg[PIX_IDX_W-1:0];
            j_reg    <= '0;
            l_reg    <= WIDX_W'(pos_reg);
            step_reg <= n_eff - POS_W'(1);
            last_reg <= (pos_reg + POS_W'(1)) >= n_eff;
        end else if (issue) begin
            j_reg    <= j_reg + PIX_IDX_W'(1);
            l_reg    <= l_reg + WIDX_W'(step_reg);
            step_reg <= step_reg - POS_W'(1);
        end
        if (emit_fire) begin
            out_data_reg <= mac_sum;
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= CFG_W'(MAX_PIXELS);
            pos_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= issue;
            if (cfg_wr_en) begin
                count_reg <= cfg_wr_data;
                pos_reg   <= '0;
            end else if (emit_fire) begin
                pos_reg <= '0;
            end else if (drained && !last_reg) begin
                pos_reg <= pos_reg + POS_W'(1);
            end
            if (emit_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // shared multiplier pair and saturating accumulator
    pqct_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .pj      (pj_rd_reg),
        .pk      (pk_reg),
        .w       (w_rd_reg),
        .busy    (mac_busy),
        .sum     (mac_sum)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* src/pqct_checker.sv */
`include "pixel_quadratic_cross_terms_assert.svh"

module pqct_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        s_tuser,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [47:0]                 m_tdata
);
    import pqct_pkg::*;

    // stalled result holds
    `PQCT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // a pixel beat occupies the sequencer
    `PQCT_ASSERT_NEXT(a_pix_busy, aclk, aresetn, s_tvalid && s_tready && s_tuser == CMD_PIXEL, !s_tready)

    // a weight load leaves the input ready in the next cycle
    `PQCT_ASSERT_NEXT(a_load_quick, aclk, aresetn, s_tvalid && s_tready && s_tuser == CMD_LOAD, s_tready)

    // a result never rises right after a beat is taken
    `PQCT_ASSERT_NOW(a_no_rise_on_take, aclk, aresetn, $rose(m_tvalid), !$past(s_tready && s_tvalid))

endmodule

bind pixel_quadratic_cross_terms pqct_checker u_pqct_checker (.*);

/* bench/tb_pixel_quadratic_cross_terms.sv */
`timescale 1ns / 100ps

module tb_pixel_quadratic_cross_terms;

    localparam int     CYCLE_LIMIT = 400000;
    // A pixel beat keeps the block busy until its terms are issued and drained.
    localparam int     DRAIN_WAIT  = 40;
    localparam int     PHASE_BEATS = 150;
    localparam longint SUM_HI      = 64'sd140737488355327;
    localparam longint SUM_LO      = -64'sd140737488355328;

    // One input beat as the stimulus side sees it.
    typedef struct {
        logic        cmd;
        logic [7:0]  widx;
        logic [23:0] wval;
        logic [15:0] pix;
        bit          wait_drain;  // hold this beat until no frame sum is outstanding
    } beat_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [pqct_pkg::CFG_W-1:0] cfg_wr_data = '0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [47:0]                s_tdata = '0;   // weight_index, weight_value, pixel_value
    logic                       s_tuser = 1'b0; // command
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [47:0]                m_tdata;        // frame_sum

    pixel_quadratic_cross_terms dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Cross-term predictor state: our own mirror of the block.
    // ------------------------------------------------------------------
    logic signed [23:0] wt_tab [pqct_pkg::WEIGHT_DEPTH];
    logic [15:0]        frame_pix [pqct_pkg::MAX_PIXELS];
    longint             acc_sum = 0;
    int                 frame_pos = 0;
    logic [4:0]         count_reg = 5'd16;

    logic [47:0]        frame_sums_due [$];  // predicted frame sums, oldest first

    // Stimulus bookkeeping.
    beat_t              beats_pending [$];
    beat_t              on_bus;
    int                 beats_queued = 0;
    int                 beats_taken = 0;
    bit                 loaded [pqct_pkg::WEIGHT_DEPTH];  // weight written, as generated
    int                 gen_n = 16;                       // frame length the generator assumes

    // Idling knobs, changed between phases.
    int                 gap_max = 0;
    int                 gap_left = 0;
    int                 burst_left = 1;
    int                 stall_pct = 0;
    int                 stall_max = 1;
    int                 stall_left = 0;

    int                 errors = 0;
    int                 cycles = 0;
    int                 n_loads = 0;
    int                 n_pixels = 0;
    int                 n_frames = 0;
    int                 n_cfg = 0;
    logic [47:0]        sum_want;

    // Register value 0 means one pixel, anything above the maximum saturates.
    function automatic int active_pixels(input logic [4:0] c);
        if (c == 5'd0) return 1;
        if (c > pqct_pkg::MAX_PIXELS) return pqct_pkg::MAX_PIXELS;
        return int'(c);
    endfunction

    // Advance the mirror by one accepted beat; queue a frame sum on the last pixel.
    task automatic cross_sum_step(input beat_t b);
        int     n;
        int     k;
        int     l;
        longint pp;
        longint term;
        longint total;
        if (b.cmd == pqct_pkg::CMD_LOAD) begin
            if (b.widx < pqct_pkg::WEIGHT_DEPTH) wt_tab[b.widx] = b.wval;
            n_loads++;
            return;
        end
        n_pixels++;
        n = active_pixels(count_reg);
        k = frame_pos;
        frame_pix[k] = b.pix;
        for (int j = 0; j <= k; j++) begin
            // row-by-row numbering over the upper triangle
            l     = j * n - j * (j - 1) / 2 + (k - j);
            pp    = longint'(frame_pix[j]) * longint'(b.pix);
            term  = (longint'(wt_tab[l]) * pp) >>> 24;  // floor the Q33.24 product to Q33.0
            total = acc_sum + term;
            if (total > SUM_HI) total = SUM_HI;
            if (total < SUM_LO) total = SUM_LO;
            acc_sum = total;
        end
        if (k + 1 >= n) begin
            frame_sums_due.push_back(acc_sum[47:0]);
            acc_sum   = 0;
            frame_pos = 0;
        end else begin
            frame_pos = k + 1;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic void add_load(input int idx, input logic [23:0] val);
        beat_t b;
        b = '{cmd: pqct_pkg::CMD_LOAD, widx: 8'(idx), wval: val,
              pix: 16'($urandom()), wait_drain: 1'b0};
        if (idx < pqct_pkg::WEIGHT_DEPTH) loaded[idx] = 1'b1;
        beats_pending.push_back(b);
        beats_queued++;
    endfunction

    function automatic logic [23:0] any_weight();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 24'h7FFFFF;
        if (r == 1) return 24'h800000;
        return 24'($urandom());
    endfunction

    // Every weight the current frame length can reach gets loaded first.
    function automatic void add_pixel(input logic [15:0] val, input bit drain);
        beat_t b;
        for (int l = 0; l < gen_n * (gen_n + 1) / 2; l++) begin
            if (!loaded[l]) add_load(l, any_weight());
        end
        b = '{cmd: pqct_pkg::CMD_PIXEL, widx: 8'($urandom()), wval: 24'($urandom()),
              pix: val, wait_drain: drain};
        beats_pending.push_back(b);
        beats_queued++;
    endfunction

    function automatic logic [15:0] any_pixel();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom());
    endfunction

    // Register write only once the block has gone quiet.
    task automatic set_pixel_count(input logic [4:0] v);
        while (beats_taken != beats_queued || frame_sums_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        // a write also restarts the frame
        count_reg = v;
        acc_sum   = 0;
        frame_pos = 0;
        gen_n     = active_pixels(v);
        n_cfg++;
    endtask

    // ------------------------------------------------------------------
    // Input driver: bursts of beats with random gaps between them.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                cross_sum_step(on_bus);
                beats_taken++;
            end
            if (s_tvalid && !s_tready) begin
                // beat stays on the bus until taken
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (beats_pending.size() != 0 &&
                         !(beats_pending[0].wait_drain && frame_sums_due.size() != 0)) begin
                on_bus = beats_pending.pop_front();
                s_tdata  <= {on_bus.pix, on_bus.wval, on_bus.widx};
                s_tuser  <= on_bus.cmd;
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side backpressure: stall runs of random length.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, stall_max);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Frame sum monitor and checker.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (frame_sums_due.size() == 0) begin
                $error("frame_sum beat with none expected: got %0d", $signed(m_tdata));
                errors++;
            end else begin
                sum_want = frame_sums_due.pop_front();
                if (m_tdata !== sum_want) begin
                    $error("frame_sum mismatch: expected %0d, actual %0d",
                           $signed(sum_want), $signed(m_tdata));
                    errors++;
                end
                n_frames++;
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d frame sums outstanding",
                     cycles, frame_sums_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int counts [$];
        int r;
        counts = '{16, 0, 31, 2, 17, 7, 1, 16, 12};
        foreach (wt_tab[i]) wt_tab[i] = '0;
        foreach (frame_pix[i]) frame_pix[i] = '0;
        foreach (loaded[i]) loaded[i] = 1'b0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: three-pixel frames over six weights, several at the extremes.
        set_pixel_count(5'd3);
        add_load(0, 24'h7FFFFF);
        add_load(1, 24'h800000);
        add_load(2, 24'hFFFFFF);   // -1: negative terms floor toward minus infinity
        add_load(3, 24'h000001);
        add_load(4, 24'h000000);
        add_load(5, 24'h400000);
        add_load(135, 24'h123456); // last table entry
        add_load(136, 24'h555555); // first index past the table, dropped
        add_load(255, 24'hAAAAAA); // all index bits set, dropped
        add_pixel(16'hFFFF, 1'b0);
        add_pixel(16'hFFFF, 1'b0);
        add_pixel(16'hFFFF, 1'b0);
        add_pixel(16'h0000, 1'b1); // sender waits for the first frame sum here
        add_pixel(16'hFFFF, 1'b0);
        add_pixel(16'h0001, 1'b0);
        add_pixel(16'h0001, 1'b0);
        add_pixel(16'h0001, 1'b0);
        add_pixel(16'h0001, 1'b0);
        // leave a frame half done, then rewrite the count
        add_pixel(16'h8000, 1'b0);
        add_pixel(16'h7FFF, 1'b0);
        set_pixel_count(5'd1);
        add_pixel(16'hFFFF, 1'b0);
        add_pixel(16'h0000, 1'b0);

        // Random phases; each may stop mid-frame before the next count write.
        foreach (counts[p]) begin
            set_pixel_count(5'(counts[p]));
            if (p == 0 || p == 5) begin
                gap_max   = 0;
                stall_pct = 0;
            end else begin
                gap_max   = $urandom_range(1, 8);
                stall_pct = $urandom_range(5, 50);
                stall_max = $urandom_range(1, 30);
            end
            repeat (PHASE_BEATS) begin
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    if ($urandom_range(0, 4) == 0) add_load($urandom_range(0, 255), any_weight());
                    else add_load($urandom_range(0, pqct_pkg::WEIGHT_DEPTH - 1), any_weight());
                end else begin
                    add_pixel(any_pixel(), $urandom_range(0, 99) < 2);
                end
            end
        end

        while (beats_taken != beats_queued || frame_sums_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("run: %0d weight loads, %0d pixel beats, %0d frame sums checked",
                 n_loads, n_pixels, n_frames);
        $display("     %0d pixel_count writes incl. 0, 31 and mid-frame restarts; %0d errors",
                 n_cfg, errors);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
